// ===== src/crc32_byte_stream_engine_core_defines.svh =====
// ---------------------------------------------------------------------------
// crc32_byte_stream_engine_core_defines.svh
// Assertion macros shared by the CRC-32 engine checkers.
// ---------------------------------------------------------------------------
`ifndef CRC32_BYTE_STREAM_ENGINE_CORE_DEFINES_SVH
`define CRC32_BYTE_STREAM_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, masked while reset is high
`define CRC32BSE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, also checked across reset
`define CRC32BSE_ASSERT_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/crc32bse_pkg.sv =====
// ---------------------------------------------------------------------------
// crc32bse_pkg
// Shared types, codes and CRC helper functions for the CRC-32 engine.
// ---------------------------------------------------------------------------
package crc32bse_pkg;

   // CRC constants
   localparam logic [31:0] CRC_POLY = 32'h04C11DB7;
   localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

   // Input item kinds
   localparam int KIND_W = 2;
   localparam logic [KIND_W-1:0] KIND_START  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_BYTE   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

   // Result status codes
   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_NO_MSG   = 1'b1;

   // Register file
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_REFLECT_MODE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEED_VALUE   = 1'b1;

   // Queue depths
   localparam int CMDQ_DEPTH = 2;
   localparam int RSPQ_DEPTH = 2;

   // Operations handed from front to back
   typedef enum logic [1:0] {
      OP_LOAD,
      OP_BYTE,
      OP_FINISH,
      OP_ERROR
   } op_type;

   typedef struct packed {
      op_type      op;
      logic        mode;    // reflected mode of the open message
      logic [31:0] value;   // seed on load, byte in [7:0] on byte
   } cmd_type;

   // Bit reversal within one byte
   function automatic logic [7:0] reverse8(input logic [7:0] b);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = b[7-i];
      end
      return r;
   endfunction

   // Full 32-bit bit reversal
   function automatic logic [31:0] mirror32(input logic [31:0] w);
      logic [31:0] r;
      for (int i = 0; i < 32; i++) begin
         r[i] = w[31-i];
      end
      return r;
   endfunction

   // Eight MSB-first shift steps of the CRC, flattened to an XOR tree
   function automatic logic [31:0] shift_byte(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] s;
      s = c ^ {b, 24'h000000};
      for (int k = 0; k < 8; k++) begin
         s = s[31] ? ({s[30:0], 1'b0} ^ CRC_POLY) : {s[30:0], 1'b0};
      end
      return s;
   endfunction

endpackage

// ===== src/crc32_byte_stream_engine_core.sv =====
// ---------------------------------------------------------------------------
// crc32_byte_stream_engine_core
// CRC-32 (poly 0x04C11DB7) byte-stream engine, MPEG-2 or reflected IEEE.
// ---------------------------------------------------------------------------
// Takes one item per clock cycle while req_full is low: start, data byte or
// finish. The front end classifies each item and the back end folds a whole
// byte into the running CRC combinationally through an eight-step XOR tree,
// which sets the one-cycle rate. A result (finish, or an error for a byte
// or finish with no open message) passes through the command queue and the
// result queue on its way to the rsp_ side. Two-entry queues sit between
// front and back and on the output, so either side may stall while the
// other keeps moving. Write reflect_mode and seed_value only while the
// engine is idle; both are sampled at the next start item.
// ---------------------------------------------------------------------------
module crc32_byte_stream_engine_core
   import crc32bse_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // item input
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [KIND_W-1:0]      req_kind,
   input  logic [7:0]             req_data_byte,
   // result output
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [31:0]            rsp_crc_out,
   output logic                   rsp_status,
   // register writes
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic    cmdq_full, cmd_push, cmd_valid, cmd_pop;
   cmd_type cmd_data, cmd_head;

   // front end
   crc32bse_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_kind      (req_kind),
      .req_data_byte (req_data_byte),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .cmdq_full     (cmdq_full),
      .cmd_push      (cmd_push),
      .cmd_data      (cmd_data)
   );

   // command queue
   crc32bse_cmdq u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_data),
      .full      (cmdq_full),
      .pop       (cmd_pop),
      .valid     (cmd_valid),
      .head      (cmd_head)
   );

   // back end
   crc32bse_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd_head    (cmd_head),
      .cmd_pop     (cmd_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_crc_out (rsp_crc_out),
      .rsp_status  (rsp_status)
   );

endmodule

// ===== src/crc32bse_front.sv =====
// ---------------------------------------------------------------------------
// crc32bse_front
// Accepts items, holds the registers and message state, and classifies
// each item into a command for the back end.
// ---------------------------------------------------------------------------
module crc32bse_front
   import crc32bse_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // item input
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [KIND_W-1:0]      req_kind,
   input  logic [7:0]             req_data_byte,
   // register writes
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   // command queue side
   input  logic                   cmdq_full,
   output logic                   cmd_push,
   output cmd_type                cmd_data
);

   logic        reflect_mode_ff, reflect_mode_in;
   logic [31:0] seed_value_ff,   seed_value_in;
   logic        in_progress_ff,  in_progress_in;
   logic        mode_ff,         mode_in;
   logic        accept;

   assign req_full = cmdq_full;
   assign accept   = req_push && !cmdq_full;

   // register writes
   always_comb begin
      reflect_mode_in = reflect_mode_ff;
      seed_value_in   = seed_value_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_REFLECT_MODE: reflect_mode_in = csr_wdata[0];
            CSR_SEED_VALUE:   seed_value_in   = csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // classify the item and track whether a message is open
   always_comb begin
      in_progress_in = in_progress_ff;
      mode_in        = mode_ff;
      cmd_push       = 1'b0;
      cmd_data.op    = OP_ERROR;
      cmd_data.mode  = mode_ff;
      cmd_data.value = '0;
      if (accept) begin
         case (req_kind)
            KIND_START: begin
               cmd_push       = 1'b1;
               cmd_data.op    = OP_LOAD;
               cmd_data.mode  = reflect_mode_ff;
               cmd_data.value = reflect_mode_ff ? mirror32(seed_value_ff) : seed_value_ff;
               in_progress_in = 1'b1;
               mode_in        = reflect_mode_ff;
            end
            KIND_BYTE: begin
               cmd_push = 1'b1;
               if (in_progress_ff) begin
                  cmd_data.op    = OP_BYTE;
                  cmd_data.value = {24'h000000,
                                    mode_ff ? reverse8(req_data_byte) : req_data_byte};
               end
            end
            KIND_FINISH: begin
               cmd_push = 1'b1;
               if (in_progress_ff) begin
                  cmd_data.op    = OP_FINISH;
                  in_progress_in = 1'b0;
               end
            end
            default: ;   // unused kind: dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reflect_mode_ff <= 1'b0;
         seed_value_ff   <= CRC_ONES;
         in_progress_ff  <= 1'b0;
         mode_ff         <= 1'b0;
      end else begin
         reflect_mode_ff <= reflect_mode_in;
         seed_value_ff   <= seed_value_in;
         in_progress_ff  <= in_progress_in;
         mode_ff         <= mode_in;
      end
   end

endmodule

// ===== src/crc32bse_cmdq.sv =====
// ---------------------------------------------------------------------------
// crc32bse_cmdq
// Short command queue between the front and the back end.
// ---------------------------------------------------------------------------
module crc32bse_cmdq
   import crc32bse_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    valid,
   output cmd_type head
);

   localparam int PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

   cmd_type          entry_ff [CMDQ_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(CMDQ_DEPTH));
   assign valid   = (count_ff != '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/crc32bse_back.sv =====
// ---------------------------------------------------------------------------
// crc32bse_back
// Executes commands on the running CRC and queues the results.
// ---------------------------------------------------------------------------
module crc32bse_back
   import crc32bse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // command queue side
   input  logic        cmd_valid,
   input  cmd_type     cmd_head,
   output logic        cmd_pop,
   // result output
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_crc_out,
   output logic        rsp_status
);

   localparam int PTR_W = $clog2(RSPQ_DEPTH);
   localparam int CNT_W = $clog2(RSPQ_DEPTH + 1);

   logic [31:0]      crc_ff, crc_in;
   logic [31:0]      rq_crc_ff    [RSPQ_DEPTH];
   logic             rq_status_ff [RSPQ_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             needs_result, rq_full, res_push, res_pop;
   logic [31:0]      res_crc;
   logic             res_status;

   assign needs_result = (cmd_head.op == OP_FINISH) || (cmd_head.op == OP_ERROR);
   assign rq_full      = (count_ff == CNT_W'(RSPQ_DEPTH));
   assign cmd_pop      = cmd_valid && (!needs_result || !rq_full);
   assign res_push     = cmd_pop && needs_result;
   assign rsp_empty    = (count_ff == '0);
   assign res_pop      = rsp_pop && !rsp_empty;
   assign rsp_crc_out  = rq_crc_ff[rd_ptr_ff];
   assign rsp_status   = rq_status_ff[rd_ptr_ff];

   // execute one command
   always_comb begin
      crc_in     = crc_ff;
      res_crc    = '0;
      res_status = STATUS_NO_MSG;
      case (cmd_head.op)
         OP_LOAD:   crc_in = cmd_head.value;
         OP_BYTE:   crc_in = shift_byte(crc_ff, cmd_head.value[7:0]);
         OP_FINISH: begin
            res_crc    = cmd_head.mode ? (mirror32(crc_ff) ^ CRC_ONES) : crc_ff;
            res_status = STATUS_OK;
         end
         default: ;   // error: zero CRC, no-message status
      endcase
   end

   // result queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (res_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(RSPQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (res_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(RSPQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (res_push && !res_pop) begin
         count_in = count_ff + 1'b1;
      end else if (res_pop && !res_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff    <= CRC_ONES;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (cmd_pop) begin
            crc_ff <= crc_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // result storage, no reset
   always_ff @(posedge clock) begin
      if (res_push) begin
         rq_crc_ff[wr_ptr_ff]    <= res_crc;
         rq_status_ff[wr_ptr_ff] <= res_status;
      end
   end

endmodule

// ===== src/crc32bse_checker.sv =====
// ---------------------------------------------------------------------------
// crc32bse_checker
// Port-level checks of the CRC-32 engine, bound to the top level.
// ---------------------------------------------------------------------------
`include "crc32_byte_stream_engine_core_defines.svh"

module crc32bse_checker
   import crc32bse_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_full,
   input logic                   rsp_empty,
   input logic                   rsp_pop,
   input logic [31:0]            rsp_crc_out,
   input logic                   rsp_status
);

   // an error item always reports a zero CRC
   `CRC32BSE_ASSERT_NOW(a_err_zero_crc, clock, reset, !rsp_empty && rsp_status == STATUS_NO_MSG, rsp_crc_out == 32'h0, "error item with nonzero CRC")

   // reset leaves both queues drained
   `CRC32BSE_ASSERT_NEXT(a_reset_clears, clock, reset, rsp_empty && !req_full, "queues not drained after reset")

   // a waiting item is not withdrawn
   `CRC32BSE_ASSERT_NEXT(a_rsp_held, clock, !reset && !rsp_empty && !rsp_pop, !rsp_empty, "waiting item dropped")

endmodule

bind crc32_byte_stream_engine_core crc32bse_checker u_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the CRC-32 byte-stream engine (MPEG-2 / IEEE).
// ---------------------------------------------------------------------------
// A clocked driver feeds start, byte, finish and unused items from a
// backlog that the stimulus process fills phase by phase. Each accepted
// item runs through a local CRC predictor, and the monitor compares every
// popped result, field by field, with the oldest predicted one. Between
// phases the mode and seed registers are rewritten while the engine is
// idle. Both sides idle at random except in one phase, and the receiver holds
// off twice for a long stretch so that the engine backs up and stalls its input.
// ---------------------------------------------------------------------------
module tb
   import crc32bse_pkg::*;
();

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int HOLD_CYCLES   = 200;
   localparam int SETTLE_CYCLES = 8;
   localparam int IDLE_PCT      = 8;
   localparam int PHASE_COUNT   = 10;
   localparam int PHASE_ITEMS   = 165;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [7:0]        data;
   } crc_item_type;

   typedef struct packed {
      logic [31:0] crc;
      logic        status;
   } crc_result_type;

   // DUT ports
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_push = 1'b0;
   logic                   req_full;
   logic [KIND_W-1:0]      req_kind = KIND_START;
   logic [7:0]             req_data_byte = 8'h00;
   logic                   rsp_empty;
   logic                   rsp_pop = 1'b0;
   logic [31:0]            rsp_crc_out;
   logic                   rsp_status;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_REFLECT_MODE;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Predictor state and register copies
   logic        cfg_reflect = 1'b0;
   logic [31:0] cfg_seed = CRC_ONES;
   logic [31:0] crc_acc = CRC_ONES;
   logic        msg_open = 1'b0;
   logic        mode_held = 1'b0;

   crc_item_type   item_backlog[$];
   crc_result_type crc_expect[$];

   int idle_pct = IDLE_PCT;
   int hold_left = 0;
   int cycle_count = 0;
   int items_taken = 0;
   int results_seen = 0;
   int error_results = 0;
   int settings_used = 1;
   int fail_count = 0;

   crc32_byte_stream_engine_core DUT (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_kind      (req_kind),
      .req_data_byte (req_data_byte),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_crc_out   (rsp_crc_out),
      .rsp_status    (rsp_status),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   // Clock
   initial begin
      forever #5 clock = ~clock;
   end

   // Run-length guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles", cycle_count);
         $display("FAILURE");
         $finish;
      end
   end

   // Bit order helpers for the reflected mode
   function automatic logic [7:0] flip8(input logic [7:0] b);
      return {b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7]};
   endfunction

   function automatic logic [31:0] flip32(input logic [31:0] w);
      return {flip8(w[7:0]), flip8(w[15:8]), flip8(w[23:16]), flip8(w[31:24])};
   endfunction

   // One byte through the MSB-first shift register
   function automatic logic [31:0] crc_fold_byte(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] s;
      s = c;
      s[31:24] = s[31:24] ^ b;
      for (int k = 0; k < 8; k++) begin
         if (s[31]) s = (s << 1) ^ CRC_POLY;
         else s = s << 1;
      end
      return s;
   endfunction

   // Advance the CRC predictor by one accepted item
   task automatic predict_crc_item(input logic [KIND_W-1:0] kind, input logic [7:0] b);
      crc_result_type r;
      r.crc = 32'h0;
      r.status = STATUS_NO_MSG;
      case (kind)
         KIND_START: begin
            mode_held = cfg_reflect;
            crc_acc = cfg_reflect ? flip32(cfg_seed) : cfg_seed;
            msg_open = 1'b1;
         end
         KIND_BYTE: begin
            if (!msg_open) begin
               crc_expect.push_back(r);
               error_results++;
            end else begin
               crc_acc = crc_fold_byte(crc_acc, mode_held ? flip8(b) : b);
            end
         end
         KIND_FINISH: begin
            if (!msg_open) begin
               error_results++;
            end else begin
               r.crc = mode_held ? ~flip32(crc_acc) : crc_acc;
               r.status = STATUS_OK;
               msg_open = 1'b0;
            end
            crc_expect.push_back(r);
         end
         default: ;
      endcase
   endtask

   task automatic queue_item(input logic [KIND_W-1:0] kind, input logic [7:0] b);
      crc_item_type it;
      it.kind = kind;
      it.data = b;
      item_backlog.push_back(it);
   endtask

   // Mostly well-formed messages with random bytes; the rest is noise
   task automatic queue_random_items(input int count);
      int n;
      int len;
      logic [KIND_W-1:0] k;
      n = 0;
      while (n < count) begin
         if ($urandom_range(0, 99) < 80) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(0, 12);
            queue_item(KIND_START, 8'($urandom));
            n++;
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(0, 99) < 5) queue_item(KIND_UNUSED, 8'($urandom));
               if ($urandom_range(0, 99) < 3) begin
                  queue_item(KIND_START, 8'($urandom));
                  n++;
               end
               if ($urandom_range(0, 7) == 0) queue_item(KIND_BYTE, $urandom_range(0, 1) ? 8'hFF : 8'h00);
               else queue_item(KIND_BYTE, 8'($urandom));
               n++;
            end
            queue_item(KIND_FINISH, 8'($urandom));
            n++;
         end else begin
            k = KIND_W'($urandom_range(0, 3));
            queue_item(k, 8'($urandom));
            if (k != KIND_UNUSED) n++;
         end
      end
   endtask

   // Register write at the clock edge; predictor copy follows
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_REFLECT_MODE) cfg_reflect = value[0];
      else if (idx == CSR_SEED_VALUE) cfg_seed = value;
   endtask

   // Wait until every item is taken and every result is back, then settle
   task automatic wait_for_drain();
      @(posedge clock);
      while (item_backlog.size() != 0 || req_push || crc_expect.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Item driver
   always @(posedge clock) begin : item_driver
      crc_item_type nxt;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            predict_crc_item(req_kind, req_data_byte);
            items_taken++;
         end
         if (!req_push || !req_full) begin
            if (item_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
               nxt = item_backlog.pop_front();
               req_push <= 1'b1;
               req_kind <= nxt.kind;
               req_data_byte <= nxt.data;
            end else begin
               req_push <= 1'b0;
               req_kind <= KIND_W'($urandom);
               req_data_byte <= 8'($urandom);
            end
         end
      end
   end

   // Result monitor and receiver stalls
   always @(posedge clock) begin : result_monitor
      crc_result_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            results_seen++;
            if (crc_expect.size() == 0) begin
               $error("unexpected result: crc_out %h status %b", rsp_crc_out, rsp_status);
               fail_count++;
            end else begin
               want = crc_expect.pop_front();
               if (rsp_crc_out !== want.crc) begin
                  $error("crc_out: expected %h, got %h", want.crc, rsp_crc_out);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %b, got %b", want.status, rsp_status);
                  fail_count++;
               end
            end
            // long hold-offs to back the engine up
            if (results_seen == 20 || results_seen == 120) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(0, 99) >= idle_pct);
         end
      end
   end

   // Stimulus phases
   initial begin : stimulus
      logic        new_reflect;
      logic [31:0] new_seed;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // default registers: MPEG-2, all-ones seed
      queue_item(KIND_FINISH, 8'h00);   // finish with no message
      queue_item(KIND_BYTE, 8'hFF);     // byte with no message
      queue_item(KIND_UNUSED, 8'h5A);
      queue_item(KIND_START, 8'h00);
      queue_item(KIND_BYTE, 8'h00);
      queue_item(KIND_BYTE, 8'hFF);
      queue_item(KIND_BYTE, 8'h80);
      queue_item(KIND_FINISH, 8'hFF);
      queue_item(KIND_FINISH, 8'h00);   // second finish finds no message
      queue_item(KIND_START, 8'h00);
      queue_item(KIND_BYTE, 8'hAA);
      queue_item(KIND_START, 8'h00);    // restart while open
      queue_item(KIND_BYTE, 8'h55);
      queue_item(KIND_UNUSED, 8'hA5);   // ignored mid-message
      queue_item(KIND_FINISH, 8'h00);
      // leave a message open across the register change
      queue_item(KIND_START, 8'h00);
      queue_item(KIND_BYTE, 8'h31);
      queue_random_items(0);

      for (int ph = 1; ph < PHASE_COUNT; ph++) begin
         wait_for_drain();
         case (ph)
            1: begin new_reflect = 1'b1; new_seed = CRC_ONES; end
            2: begin new_reflect = 1'b0; new_seed = 32'h0; end
            3: begin new_reflect = 1'b1; new_seed = 32'h0; end
            4: begin new_reflect = 1'b0; new_seed = CRC_ONES; end
            default: begin new_reflect = 1'($urandom_range(0, 1)); new_seed = $urandom; end
         endcase
         write_csr(CSR_REFLECT_MODE, {$urandom_range(0, 1) ? 31'h7FFFFFFF : 31'h0, new_reflect});
         write_csr(CSR_SEED_VALUE, new_seed);
         settings_used++;
         idle_pct = (ph == 4) ? 0 : IDLE_PCT;
         if (ph == 1) begin
            // open message keeps MPEG-2 mode and old seed
            queue_item(KIND_BYTE, 8'h32);
            queue_item(KIND_FINISH, 8'h00);
            // check string under the new IEEE setting
            queue_item(KIND_START, 8'h00);
            for (int i = 1; i <= 9; i++) queue_item(KIND_BYTE, 8'(8'h30 + i));
            queue_item(KIND_FINISH, 8'h00);
         end
         queue_random_items(PHASE_ITEMS);
      end
      wait_for_drain();

      $display("Ran %0d items over %0d register settings in both CRC modes", items_taken,
               settings_used);
      $display("Checked %0d results, %0d of them no-message errors", results_seen, error_results);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
